### design/follow_depth_setpoint_step_unit_macros.svh
// ----------------------------------------------------------------------------
// follow_depth_setpoint_step_unit_macros: assertion helpers
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FOLLOW_DEPTH_SETPOINT_STEP_UNIT_MACROS_SVH
`define FOLLOW_DEPTH_SETPOINT_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define FDSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fdss_pkg.sv
// ----------------------------------------------------------------------------
// fdss_pkg: shared types and constants
// Field widths, register indexes, reset values and the controller command.
// ----------------------------------------------------------------------------
package fdss_pkg;

  localparam int DepthW   = 24;
  localparam int SpeedW   = 24;
  localparam int CapW     = 23;
  localparam int ScaleW   = 16;
  localparam int PosW     = 32;
  localparam int QuatW    = 16;
  localparam int QProdW   = 32;
  localparam int CoefW    = 34;
  localparam int StepW    = 25;
  localparam int SProdW   = 40;
  localparam int RProdW   = 59;
  localparam int OffW     = 31;
  localparam int SumW     = 34;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [DepthW-1:0] NearReset   = 24'd147456;
  localparam logic [DepthW-1:0] FarReset    = 24'd212992;
  localparam logic [DepthW-1:0] TargetReset = 24'd163840;
  localparam logic [CapW-1:0]   CapReset    = 23'd32768;
  localparam logic [ScaleW-1:0] ScaleReset  = 16'd3277;

  // 1.0 in Q.28, rounding offsets
  localparam logic signed [CoefW-1:0]  CoefOne   = 34'sd268435456;
  localparam logic [SProdW-1:0]        StepHalf  = 40'd32768;
  localparam logic signed [RProdW-1:0] RotHalf   = 59'sd134217728;
  localparam logic signed [SumW-1:0]   SatMax    = 34'sd2147483647;
  localparam logic signed [SumW-1:0]   SatMin    = -34'sd2147483648;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEAR   = 3'd0,
    CFG_FAR    = 3'd1,
    CFG_TARGET = 3'd2,
    CFG_CAP    = 3'd3,
    CFG_SCALE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic  load;      // capture item
    logic  prod_en;   // step and quaternion products
    logic  coef_en;   // signed step, rotation column
    logic  mul_en;    // shared rotation multiplier
    axis_e mul_sel;
    logic  add_en;    // round, add, saturate
    axis_e add_sel;
    logic  out_load;  // move result to output register
  } cmd_t;

endpackage

### design/fdss_ctrl.sv
// ----------------------------------------------------------------------------
// fdss_ctrl: sequencer
// Steps one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module fdss_ctrl import fdss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PROD, ST_COEF, ST_MUL0, ST_MUL1, ST_MUL2, ST_ADD2, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cmd_o.mul_sel = AXIS_X;
    cmd_o.add_sel = AXIS_X;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod_en = 1'b1;
        state_d       = ST_COEF;
      end
      ST_COEF: begin
        cmd_o.coef_en = 1'b1;
        state_d       = ST_MUL0;
      end
      ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = AXIS_X;
        state_d       = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = AXIS_Y;
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = AXIS_X;
        state_d       = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = AXIS_Z;
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = AXIS_Y;
        state_d       = ST_ADD2;
      end
      ST_ADD2: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = AXIS_Z;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "follow_depth_setpoint_step_unit_macros.svh"

  `FDSS_ASSERT_NEXT(a_load_starts, cmd_o.load, state_q == ST_PROD, "item capture lost")
  `FDSS_ASSERT_NEXT(a_done_waits, (state_q == ST_DONE) && !out_free, state_q == ST_DONE, "result dropped while output full")
  `FDSS_ASSERT_NEXT(a_out_loaded, cmd_o.out_load, out_valid_q, "loaded result not presented")
  `FDSS_ASSERT_SAME(a_no_overwrite, cmd_o.out_load, !out_valid_q || out_ready_i, "pending result overwritten")

endmodule

### design/fdss_dp.sv
// ----------------------------------------------------------------------------
// fdss_dp: datapath
// Config registers, held depth, step and rotation arithmetic, output register.
// ----------------------------------------------------------------------------
module fdss_dp import fdss_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  input  logic [DepthW-1:0]         object_depth_i,
  input  logic signed [SpeedW-1:0]  approach_speed_i,
  input  logic signed [PosW-1:0]    pos_x_i,
  input  logic signed [PosW-1:0]    pos_y_i,
  input  logic signed [PosW-1:0]    pos_z_i,
  input  logic signed [QuatW-1:0]   quat_w_i,
  input  logic signed [QuatW-1:0]   quat_x_i,
  input  logic signed [QuatW-1:0]   quat_y_i,
  input  logic signed [QuatW-1:0]   quat_z_i,
  output logic                      moved_o,
  output logic signed [PosW-1:0]    set_x_o,
  output logic signed [PosW-1:0]    set_y_o,
  output logic signed [PosW-1:0]    set_z_o
);

  // config and held depth
  logic [DepthW-1:0] near_q, far_q, target_q, last_depth_q;
  logic [CapW-1:0]   cap_q;
  logic [ScaleW-1:0] scale_q;

  // captured item
  logic                     move_q, neg_q;
  logic [SpeedW-1:0]        mag_q;
  logic signed [PosW-1:0]   px_q, py_q, pz_q;
  logic signed [QuatW-1:0]  qw_q, qx_q, qy_q, qz_q;

  // products and coefficients
  logic [SProdW-1:0]        sprod_q;
  logic signed [QProdW-1:0] qyy_q, qzz_q, qxy_q, qzw_q, qxz_q, qyw_q;
  logic signed [StepW-1:0]  step_q;
  logic signed [CoefW-1:0]  c0_q, c1_q, c2_q;
  logic signed [RProdW-1:0] rprod_q;
  logic signed [PosW-1:0]   sx_q, sy_q, sz_q;

  logic [DepthW-1:0]        depth_sel;
  logic [SpeedW-1:0]        spd_abs, cap_ext, mag_min;
  logic                     move;
  logic [SProdW-1:0]        sround;
  logic [DepthW-1:0]        step_mag;
  logic signed [StepW-1:0]  step_pos;
  logic signed [CoefW-1:0]  s0, s1, s2, csel;
  logic signed [RProdW-1:0] rround;
  logic signed [OffW-1:0]   off;
  logic signed [PosW-1:0]   psel, sat;
  logic signed [SumW-1:0]   tot;

  // zero depth means missing: fall back to the held value
  assign depth_sel = (object_depth_i == '0) ? last_depth_q : object_depth_i;
  assign move      = (depth_sel <= near_q) || (depth_sel >= far_q);
  // -2^23 maps to 2^23, fits unsigned 24
  assign spd_abs   = approach_speed_i[SpeedW-1] ? SpeedW'(-approach_speed_i)
                                                : SpeedW'(approach_speed_i);
  assign cap_ext   = {1'b0, cap_q};
  assign mag_min   = (spd_abs < cap_ext) ? spd_abs : cap_ext;

  assign sround    = sprod_q + StepHalf;
  assign step_mag  = sround[SProdW-1:16];
  assign step_pos  = $signed({1'b0, step_mag});

  assign s0 = SumW'(qyy_q) + SumW'(qzz_q);
  assign s1 = SumW'(qxy_q) + SumW'(qzw_q);
  assign s2 = SumW'(qxz_q) - SumW'(qyw_q);

  always_comb begin
    unique case (cmd_i.mul_sel)
      AXIS_X:  csel = c0_q;
      AXIS_Y:  csel = c1_q;
      AXIS_Z:  csel = c2_q;
      default: csel = c0_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.add_sel)
      AXIS_X:  psel = px_q;
      AXIS_Y:  psel = py_q;
      AXIS_Z:  psel = pz_q;
      default: psel = px_q;
    endcase
  end

  // floor shift by 28 after adding half
  assign rround = rprod_q + RotHalf;
  assign off    = rround[RProdW-1:28];
  assign tot    = SumW'(psel) + SumW'(off);

  always_comb begin
    priority if (tot > SatMax) begin
      sat = PosW'(SatMax);
    end else if (tot < SatMin) begin
      sat = PosW'(SatMin);
    end else begin
      sat = tot[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q       <= NearReset;
      far_q        <= FarReset;
      target_q     <= TargetReset;
      cap_q        <= CapReset;
      scale_q      <= ScaleReset;
      last_depth_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_NEAR:   near_q   <= cfg_wdata_i[DepthW-1:0];
          CFG_FAR:    far_q    <= cfg_wdata_i[DepthW-1:0];
          CFG_TARGET: target_q <= cfg_wdata_i[DepthW-1:0];
          CFG_CAP:    cap_q    <= cfg_wdata_i[CapW-1:0];
          CFG_SCALE:  scale_q  <= cfg_wdata_i[ScaleW-1:0];
          default:    ;
        endcase
      end
      if (cmd_i.load) begin
        last_depth_q <= depth_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      move_q <= move;
      neg_q  <= !(depth_sel > target_q);
      // hold case: zero step leaves the position untouched
      mag_q  <= move ? mag_min : '0;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      qw_q   <= quat_w_i;
      qx_q   <= quat_x_i;
      qy_q   <= quat_y_i;
      qz_q   <= quat_z_i;
    end
    if (cmd_i.prod_en) begin
      sprod_q <= mag_q * scale_q;
      qyy_q   <= qy_q * qy_q;
      qzz_q   <= qz_q * qz_q;
      qxy_q   <= qx_q * qy_q;
      qzw_q   <= qz_q * qw_q;
      qxz_q   <= qx_q * qz_q;
      qyw_q   <= qy_q * qw_q;
    end
    if (cmd_i.coef_en) begin
      step_q <= neg_q ? -step_pos : step_pos;
      c0_q   <= CoefOne - (s0 <<< 1);
      c1_q   <= s1 <<< 1;
      c2_q   <= s2 <<< 1;
    end
    if (cmd_i.mul_en) begin
      rprod_q <= step_q * csel;
    end
    if (cmd_i.add_en) begin
      unique case (cmd_i.add_sel)
        AXIS_X:  sx_q <= sat;
        AXIS_Y:  sy_q <= sat;
        AXIS_Z:  sz_q <= sat;
        default: sx_q <= sat;
      endcase
    end
    if (cmd_i.out_load) begin
      moved_o <= move_q;
      set_x_o <= sx_q;
      set_y_o <= sy_q;
      set_z_o <= sz_q;
    end
  end

endmodule

### design/follow_depth_setpoint_step_unit.sv
// ----------------------------------------------------------------------------
// follow_depth_setpoint_step_unit: depth-keeping setpoint step
// Moves the position setpoint along body x when the object depth leaves its band.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o): depth, approach speed, Q16.16
//   position and Q1.14 quaternion, one item per handshake.
//   Output channel (out_valid_o / out_ready_i): moved flag and the saturated
//   Q16.16 setpoint, exactly one result item per input item.
//   Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once;
//   write only while no item is in flight. Unlisted indexes are ignored.
// Timing
//   A new item is taken only while the sequencer is idle. For each item it walks
//   capture, products, coefficients and three passes of one shared 25x34
//   rotation multiplier, then loads the output register and returns to idle.
//   The output register decouples the sides: with a result still waiting the
//   next item is taken and computed, and only the final load stalls.
// Reset
//   Config registers return to their defaults, the held depth clears to zero
//   and the output channel empties. No clearing pass is needed.
// ----------------------------------------------------------------------------
module follow_depth_setpoint_step_unit import fdss_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  // input item
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [DepthW-1:0]         object_depth_i,
  input  logic signed [SpeedW-1:0]  approach_speed_i,
  input  logic signed [PosW-1:0]    pos_x_i,
  input  logic signed [PosW-1:0]    pos_y_i,
  input  logic signed [PosW-1:0]    pos_z_i,
  input  logic signed [QuatW-1:0]   quat_w_i,
  input  logic signed [QuatW-1:0]   quat_x_i,
  input  logic signed [QuatW-1:0]   quat_y_i,
  input  logic signed [QuatW-1:0]   quat_z_i,
  // result item
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      moved_o,
  output logic signed [PosW-1:0]    set_x_o,
  output logic signed [PosW-1:0]    set_y_o,
  output logic signed [PosW-1:0]    set_z_o
);

  // sequencer to datapath commands
  cmd_t cmd;

  fdss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // all arithmetic, config and the held depth live here
  fdss_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .object_depth_i   (object_depth_i),
    .approach_speed_i (approach_speed_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .quat_w_i         (quat_w_i),
    .quat_x_i         (quat_x_i),
    .quat_y_i         (quat_y_i),
    .quat_z_i         (quat_z_i),
    .moved_o          (moved_o),
    .set_x_o          (set_x_o),
    .set_y_o          (set_y_o),
    .set_z_o          (set_z_o)
  );

endmodule
